/* hw/rtl/pru_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_pkg
// Shared widths, register map and the types passed between the front end,
// the job queue and the write generator of the pixel replication upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

	// Field and counter widths
	localparam int PIXEL_W    = 32;
	localparam int INDEX_BITS = 28;
	localparam int COUNT_W    = 12;
	localparam int LIMIT_W    = 13;
	localparam int PITCH_W    = 15;
	localparam int SHIFT_W    = 2;
	localparam int SCALED_W   = COUNT_W + 2;
	localparam int PROD_W     = SCALED_W + PITCH_W;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	// Raster limits
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	// Job queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	// Register map, by word index
	typedef enum logic [1:0] {
		REG_SCALE  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_PITCH  = 2'd3
	} reg_idx_t;

	// Effective configuration, already clamped
	typedef struct packed {
		logic [SHIFT_W-1:0] shift;
		logic [LIMIT_W-1:0] width_lim;
		logic [LIMIT_W-1:0] height_lim;
		logic [PITCH_W-1:0] pitch;
	} cfg_t;

	// One pixel's replication job
	typedef struct packed {
		logic [PIXEL_W-1:0]    pixel;
		logic [INDEX_BITS-1:0] row_base;
		logic [SCALED_W-1:0]   col_base;
		logic [SHIFT_W-1:0]    shift;
		logic                  frame_wrap;
	} job_t;

	// Clamp a raster limit: zero reads as one, large values saturate
	function automatic logic [LIMIT_W-1:0] clamp_limit(
		input logic [LIMIT_W-1:0] v,
		input logic [LIMIT_W-1:0] maxv
	);
		logic [LIMIT_W-1:0] r;
		if (v == '0) begin
			r = LIMIT_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/pixel_replication_upscaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_replication_upscaler
// Nearest-neighbor integer upscaler: each source pixel becomes an s-by-s block
// of screen writes (s = 1, 2 or 4), with APB control registers.
//
//   channel   handshake                 payload
//   source    src_valid / src_ready     source_pixel
//   dest      dst_valid / dst_ready     dest_index, dest_pixel, last_of_run,
//                                       frame_end
//   control   APB psel/penable/pready   paddr, pwdata, prdata
//
// The write generator emits one word per cycle unless the dest port stalls,
// so a pixel costs s*s writes (1, 4 or 16); the front end takes a pixel per
// cycle unless the queue is full. Each job passes two front stages, the
// queue, job and output registers; the four-deep queue decouples both
// sides. A stalled dest port holds the output word and backs up the queue.
// Reset clears counters and control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pixel_replication_upscaler
	import pru_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  logic [PIXEL_W-1:0]    source_pixel,
	output logic                  dst_valid,
	input  logic                  dst_ready,
	output logic [INDEX_BITS-1:0] dest_index,
	output logic [PIXEL_W-1:0]    dest_pixel,
	output logic                  last_of_run,
	output logic                  frame_end
);

	logic [SHIFT_W-1:0] scale_q;
	logic [LIMIT_W-1:0] width_q, height_q;
	logic [PITCH_W-1:0] pitch_q;

	reg_idx_t reg_sel;
	logic     wr_en;
	cfg_t     cfg;

	logic push, q_full, pop, head_valid;
	job_t push_job, head_job;

	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= '0;
			width_q  <= LIMIT_W'(1);
			height_q <= LIMIT_W'(1);
			pitch_q  <= PITCH_W'(1);
		end else if (wr_en) begin
			case (reg_sel)
				REG_SCALE:  scale_q  <= pwdata[SHIFT_W-1:0];
				REG_WIDTH:  width_q  <= pwdata[LIMIT_W-1:0];
				REG_HEIGHT: height_q <= pwdata[LIMIT_W-1:0];
				REG_PITCH:  pitch_q  <= pwdata[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_sel)
			REG_SCALE:  prdata = DATA_W'(scale_q);
			REG_WIDTH:  prdata = DATA_W'(width_q);
			REG_HEIGHT: prdata = DATA_W'(height_q);
			REG_PITCH:  prdata = DATA_W'(pitch_q);
			default:    prdata = '0;
		endcase
	end

	// Effective settings: shift three acts as quadruple
	assign cfg.shift      = scale_q[1] ? 2'd2 : scale_q;
	assign cfg.width_lim  = clamp_limit(width_q, LIMIT_W'(MAX_WIDTH));
	assign cfg.height_lim = clamp_limit(height_q, LIMIT_W'(MAX_HEIGHT));
	assign cfg.pitch      = pitch_q;

	pru_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.source_pixel (source_pixel),
		.push         (push),
		.push_job     (push_job),
		.q_full       (q_full)
	);

	pru_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	pru_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pitch       (pitch_q),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.dst_valid   (dst_valid),
		.dst_ready   (dst_ready),
		.dest_index  (dest_index),
		.dest_pixel  (dest_pixel),
		.last_of_run (last_of_run),
		.frame_end   (frame_end)
	);

endmodule

/* hw/rtl/pru_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_front
// Accepts source pixels, tracks the raster position and computes the screen
// row base of each pixel's block in a two-stage pipe feeding the job queue.
// ----------------------------------------------------------------------------
module pru_front
	import pru_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               src_valid,
	output logic               src_ready,
	input  logic [PIXEL_W-1:0] source_pixel,
	output logic               push,
	output job_t               push_job,
	input  logic               q_full
);

	logic [COUNT_W-1:0]  col_q, row_q;
	logic                v_s1, v_s2;
	logic [PIXEL_W-1:0]  pixel_s1;
	logic [SCALED_W-1:0] row_scaled_s1, col_base_s1;
	logic [SHIFT_W-1:0]  shift_s1;
	logic                fwrap_s1;
	job_t                job_s2;

	logic                accept, adv_s1, adv_s2;
	logic [LIMIT_W-1:0]  col_inc, row_inc;
	logic                row_wrap, frame_wrap;
	logic [PROD_W-1:0]   product;

	// Stall control, back to front
	assign adv_s2    = v_s2 && !q_full;
	assign adv_s1    = v_s1 && (!v_s2 || adv_s2);
	assign src_ready = !v_s1 || adv_s1;
	assign accept    = src_valid && src_ready;

	// Raster position of this pixel
	assign col_inc    = {1'b0, col_q} + LIMIT_W'(1);
	assign row_inc    = {1'b0, row_q} + LIMIT_W'(1);
	assign row_wrap   = col_inc >= cfg.width_lim;
	assign frame_wrap = row_wrap && (row_inc >= cfg.height_lim);

	// Row base of the block, truncated to the index width
	assign product = PROD_W'(row_scaled_s1) * PROD_W'(cfg.pitch);

	// Advance raster counters on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_wrap) begin
				col_q <= '0;
				if (frame_wrap) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[COUNT_W-1:0];
				end
			end else begin
				col_q <= col_inc[COUNT_W-1:0];
			end
		end
	end

	// Pipe valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (src_ready) begin
				v_s1 <= src_valid;
			end
			if (!v_s2 || adv_s2) begin
				v_s2 <= adv_s1;
			end
		end
	end

	// Stage 1: scaled row and column
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1      <= source_pixel;
			row_scaled_s1 <= SCALED_W'(row_q) << cfg.shift;
			col_base_s1   <= SCALED_W'(col_q) << cfg.shift;
			shift_s1      <= cfg.shift;
			fwrap_s1      <= frame_wrap;
		end
	end

	// Stage 2: finished job
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			job_s2.pixel      <= pixel_s1;
			job_s2.row_base   <= product[INDEX_BITS-1:0];
			job_s2.col_base   <= col_base_s1;
			job_s2.shift      <= shift_s1;
			job_s2.frame_wrap <= fwrap_s1;
		end
	end

	assign push     = adv_s2;
	assign push_job = job_s2;

	ap_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into a full queue");

endmodule

/* hw/rtl/pru_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_queue
// Small job queue that lets the front end run ahead of the write generator.
// ----------------------------------------------------------------------------
module pru_queue
	import pru_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full       = count_q == Q_CNT_W'(Q_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Move pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	ap_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

	ap_level: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue level beyond depth");

endmodule

/* hw/rtl/pru_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_back
// Write generator: walks the s-by-s block of one job, row outer and column
// inner, one write per cycle to a registered output word unless dest stalls.
// ----------------------------------------------------------------------------
module pru_back
	import pru_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PITCH_W-1:0]    pitch,
	input  logic                  head_valid,
	input  job_t                  head_job,
	output logic                  pop,
	output logic                  dst_valid,
	input  logic                  dst_ready,
	output logic [INDEX_BITS-1:0] dest_index,
	output logic [PIXEL_W-1:0]    dest_pixel,
	output logic                  last_of_run,
	output logic                  frame_end
);

	logic                  active_q;
	logic [PIXEL_W-1:0]    pixel_q;
	logic [INDEX_BITS-1:0] start_q;
	logic [1:0]            c_q, r_q, mask_q;
	logic                  fwrap_q;

	logic                  out_v_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [PIXEL_W-1:0]    pix_q;
	logic                  last_q, fend_q;

	logic                  emit, last, row_end;

	assign emit    = active_q && (!out_v_q || dst_ready);
	assign row_end = c_q == mask_q;
	assign last    = row_end && (r_q == mask_q);
	assign pop     = head_valid && (!active_q || (emit && last));

	// Walk the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (pop) begin
			active_q <= 1'b1;
		end else if (emit && last) begin
			active_q <= 1'b0;
		end
	end

	// Load a job or step to the next write
	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_q <= head_job.pixel;
			start_q <= head_job.row_base + INDEX_BITS'(head_job.col_base);
			mask_q  <= {head_job.shift[1], head_job.shift[1] | head_job.shift[0]};
			fwrap_q <= head_job.frame_wrap;
			c_q     <= '0;
			r_q     <= '0;
		end else if (emit) begin
			if (row_end) begin
				c_q     <= '0;
				r_q     <= r_q + 2'd1;
				start_q <= start_q + INDEX_BITS'(pitch);
			end else begin
				c_q <= c_q + 2'd1;
			end
		end
	end

	// Hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (dst_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			idx_q  <= start_q + INDEX_BITS'(c_q);
			pix_q  <= pixel_q;
			last_q <= last;
			fend_q <= last && fwrap_q;
		end
	end

	assign dst_valid   = out_v_q;
	assign dest_index  = idx_q;
	assign dest_pixel  = pix_q;
	assign last_of_run = last_q;
	assign frame_end   = fend_q;

	ap_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && fend_q |-> last_q)
		else $error("frame end without end of run");

	ap_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> ((c_q & ~mask_q) == 2'd0) && ((r_q & ~mask_q) == 2'd0))
		else $error("block position beyond replication factor");

	ap_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop && active_q |-> emit && last)
		else $error("job loaded over a running block");

endmodule

/* sim/pixel_replication_upscaler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_replication_upscaler_tb
// Self-checking bench for the pixel replication upscaler. Source pixels go in
// over valid/ready, and the registers are programmed over APB while the block
// is idle. A scoreboard predicts every screen write (index, pixel, run and
// frame flags) and checks each write word in order as it leaves the block.
// The run covers directed corner settings, a stretch at saturated sizes with
// no idling, and random settings with random idling and a long stall on the
// dest port.
// ----------------------------------------------------------------------------
module pixel_replication_upscaler_tb
	import pru_pkg::*;
;

	localparam int HALF_PERIOD  = 2;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 75;
	localparam int DRAIN_CYCLES = 24;

	// One expected or observed screen write
	typedef struct packed {
		logic [INDEX_BITS-1:0] index;
		logic [PIXEL_W-1:0]    pixel;
		logic                  last;
		logic                  fend;
	} screen_write_t;

	// Predicts the screen writes of each pixel and checks them in order
	class upscale_scoreboard;
		logic [SHIFT_W-1:0] scale;
		logic [LIMIT_W-1:0] width;
		logic [LIMIT_W-1:0] height;
		logic [PITCH_W-1:0] pitch;
		logic [COUNT_W-1:0] col_pos;
		logic [COUNT_W-1:0] row_pos;
		screen_write_t      pending_writes[$];
		longint unsigned    index_mask;
		int                 errors;
		int                 reported;

		function new();
			scale      = '0;
			width      = LIMIT_W'(1);
			height     = LIMIT_W'(1);
			pitch      = PITCH_W'(1);
			col_pos    = '0;
			row_pos    = '0;
			index_mask = (64'd1 << INDEX_BITS) - 64'd1;
			errors     = 0;
			reported   = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_SCALE:  scale  = value[SHIFT_W-1:0];
				REG_WIDTH:  width  = value[LIMIT_W-1:0];
				REG_HEIGHT: height = value[LIMIT_W-1:0];
				REG_PITCH:  pitch  = value[PITCH_W-1:0];
				default: ;
			endcase
		endfunction

		// Zero reads as one, oversize saturates
		function int unsigned extent(logic [LIMIT_W-1:0] v, int unsigned maxv);
			if (v == '0) return 1;
			if (v > maxv) return maxv;
			return 32'(v);
		endfunction

		function int pending();
			return pending_writes.size();
		endfunction

		// Expand one accepted pixel into its block of writes, then advance the raster
		function void replicate_pixel(logic [PIXEL_W-1:0] pix);
			int unsigned     sh;
			int unsigned     span;
			int unsigned     w;
			int unsigned     h;
			longint unsigned row_base;
			longint unsigned idx;
			bit              row_wrap;
			bit              frame_wrap;
			screen_write_t   wr;
			sh         = (scale > 2) ? 2 : scale;
			span       = 1 << sh;
			w          = extent(width, MAX_WIDTH);
			h          = extent(height, MAX_HEIGHT);
			row_wrap   = (col_pos + 1) >= w;
			frame_wrap = row_wrap && ((row_pos + 1) >= h);
			row_base   = 64'(row_pos);
			row_base   = ((row_base << sh) * pitch) & index_mask;
			for (int unsigned r = 0; r < span; r++) begin
				for (int unsigned c = 0; c < span; c++) begin
					idx = row_base + r * pitch;
					idx = (idx + (longint'(col_pos) << sh) + c) & index_mask;
					wr.index = idx[INDEX_BITS-1:0];
					wr.pixel = pix;
					wr.last  = (r == span - 1) && (c == span - 1);
					wr.fend  = wr.last && frame_wrap;
					pending_writes.push_back(wr);
				end
			end
			if (row_wrap) begin
				col_pos = '0;
				row_pos = frame_wrap ? '0 : row_pos + 1'b1;
			end else begin
				col_pos = col_pos + 1'b1;
			end
		endfunction

		function void check_write(screen_write_t got);
			screen_write_t want;
			if (pending_writes.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected write: idx %h pix %h last %b end %b",
						got.index, got.pixel, got.last, got.fend);
				end
				return;
			end
			want = pending_writes.pop_front();
			if (got.index !== want.index || got.pixel !== want.pixel ||
				got.last !== want.last || got.fend !== want.fend) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("write mismatch: want idx %h pix %h last %b end %b",
						want.index, want.pixel, want.last, want.fend);
					$display("                got  idx %h pix %h last %b end %b",
						got.index, got.pixel, got.last, got.fend);
				end
			end
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [ADDR_W-1:0]     paddr        = '0;
	logic [DATA_W-1:0]     pwdata       = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	logic                  src_valid    = 1'b0;
	logic                  src_ready;
	logic [PIXEL_W-1:0]    source_pixel = '0;
	logic                  dst_valid;
	logic                  dst_ready    = 1'b0;
	logic [INDEX_BITS-1:0] dest_index;
	logic [PIXEL_W-1:0]    dest_pixel;
	logic                  last_of_run;
	logic                  frame_end;

	logic calm      = 1'b0;
	int   hold_req  = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   stall_cnt = 0;

	upscale_scoreboard sb = new();

	pixel_replication_upscaler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.source_pixel (source_pixel),
		.dst_valid    (dst_valid),
		.dst_ready    (dst_ready),
		.dest_index   (dest_index),
		.dest_pixel   (dest_pixel),
		.last_of_run  (last_of_run),
		.frame_end    (frame_end)
	);

	always #HALF_PERIOD clk = ~clk;

	// Dest side: check each accepted word, idle at random, hold off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (dst_valid && dst_ready) begin
				sb.check_write({dest_index, dest_pixel, last_of_run, frame_end});
			end
			if (hold_left > 0) begin
				dst_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_CYCLES;
				dst_ready <= 1'b0;
			end else begin
				dst_ready <= calm || ($urandom_range(0, 99) >= 18);
			end
		end
	end

	// Watchdog: end the run if no word moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && src_ready) || (dst_valid && dst_ready) || (psel && penable)) begin
				stall_cnt <= 0;
			end else if (stall_cnt >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
		end
	end

	// Lower valid and hold until every predicted write has left the block
	task automatic wait_drain();
		src_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// One APB write: setup cycle then access cycle; select stays up between writes
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx) << 2;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
	endtask

	// Program all registers once the block is idle; junk fills unused upper bits
	task automatic program_regs(input logic [SHIFT_W-1:0] sh, input logic [LIMIT_W-1:0] w,
		input logic [LIMIT_W-1:0] h, input logic [PITCH_W-1:0] p, input bit junk);
		logic [DATA_W-1:0] hi;
		wait_drain();
		hi = junk ? $urandom : '0;
		write_reg(REG_SCALE,  {hi[DATA_W-1:SHIFT_W], sh});
		write_reg(REG_WIDTH,  {hi[DATA_W-1:LIMIT_W], w});
		write_reg(REG_HEIGHT, {hi[DATA_W-1:LIMIT_W], h});
		write_reg(REG_PITCH,  {hi[DATA_W-1:PITCH_W], p});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer one pixel, idling first at random, and wait for it to be taken
	task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
		while (!calm && $urandom_range(0, 99) < 18) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid    <= 1'b1;
		source_pixel <= pix;
		do @(posedge clk); while (!src_ready);
		sb.replicate_pixel(pix);
	endtask

	task automatic run_pixels(input int n);
		for (int i = 0; i < n; i++) begin
			send_pixel($urandom);
		end
	endtask

	initial begin
		logic [SHIFT_W-1:0] sh;
		logic [LIMIT_W-1:0] w;
		logic [LIMIT_W-1:0] h;
		logic [PITCH_W-1:0] p;
		int                 sent;
		int                 n;
		bit                 first;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: plain copy of a one-pixel frame
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);

		// Copy scale, small frame, pixel extremes and alternating bits
		program_regs(2'd0, 13'd3, 13'd2, 15'd5, 1'b0);
		send_pixel(32'hA5A5_A5A5);
		send_pixel(32'h5A5A_5A5A);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		send_pixel(32'h8000_0001);
		send_pixel(32'h7FFF_FFFE);

		// Double and quadruple scale
		program_regs(2'd1, 13'd2, 13'd2, 15'd8, 1'b0);
		run_pixels(4);
		program_regs(2'd2, 13'd2, 13'd1, 15'd16384, 1'b0);
		run_pixels(2);

		// Scale three reads as quadruple; zero sizes read as one; zero pitch
		program_regs(2'd3, 13'd0, 13'd0, 15'd0, 1'b1);
		run_pixels(2);

		// Shrink the width mid-row so the column counter sits past the new limit
		program_regs(2'd0, 13'd8, 13'd3, 15'd32767, 1'b0);
		run_pixels(5);
		program_regs(2'd1, 13'd3, 13'd3, 15'd100, 1'b1);
		run_pixels(2);

		// Saturated sizes at quadruple scale with no idling on either side
		program_regs(2'd2, 13'd8191, 13'd8191, 15'd32767, 1'b0);
		calm <= 1'b1;
		run_pixels(12);
		calm <= 1'b0;

		// Random settings, counters carried across phases
		sent  = 0;
		first = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			sh = SHIFT_W'($urandom_range(0, 2));
			if ($urandom_range(0, 9) == 0) sh = 2'd3;
			case ($urandom_range(0, 9))
				0:       w = '0;
				1:       w = LIMIT_W'($urandom_range(MAX_WIDTH + 1, 8191));
				default: w = LIMIT_W'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 9))
				0:       h = '0;
				1:       h = LIMIT_W'($urandom_range(MAX_HEIGHT + 1, 8191));
				default: h = LIMIT_W'($urandom_range(1, 4));
			endcase
			case ($urandom_range(0, 9))
				0:       p = '0;
				1:       p = PITCH_W'($urandom_range(16384, 32767));
				2:       p = PITCH_W'($urandom_range(1, 16384));
				default: p = PITCH_W'($urandom_range(1, 64));
			endcase
			n = int'($urandom_range(6, 20));
			if (first) begin
				sh = 2'd2;
				n  = 20;
			end
			program_regs(sh, w, h, p, 1'($urandom_range(0, 1)));
			// Long dest stall while pixels keep coming, so the queue backs up
			if (first) begin
				hold_req <= hold_req + 1;
			end
			run_pixels(n);
			sent  = sent + n;
			first = 1'b0;
		end

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/pru_pkg.sv
hw/rtl/pru_front.sv
hw/rtl/pru_queue.sv
hw/rtl/pru_back.sv
hw/rtl/pixel_replication_upscaler.sv
sim/pixel_replication_upscaler_tb.sv
